// ===== rtl/core/bdq_pkg.sv =====
// Shared types, codes and sizes for the bounded deque with index read.
package bdq_pkg;

  localparam int CAPACITY  = 256;
  localparam int ELEM_BITS = 32;
  localparam int PTR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  // Fixed field widths of the stream payloads.
  localparam int FUNC_W  = 3;
  localparam int ELEM_W  = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_REM_HEAD = 3'd2,
    FN_REM_TAIL = 3'd3,
    FN_RD_HEAD  = 3'd4,
    FN_RD_TAIL  = 3'd5,
    FN_RD_INDEX = 3'd6
  } bdq_func_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } bdq_status_t;

  // Result of one request, minus the memory read data.
  typedef struct packed {
    logic              hit;
    logic [CNT_W-1:0]  count;
    bdq_status_t       status;
  } bdq_rsp_t;

endpackage

// ===== rtl/core/bdq_ring.sv =====
// Ring storage of the deque: head pointer, fill count and the element memory.
module bdq_ring
  import bdq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  input  logic [FUNC_W-1:0]     req_func,
  input  logic [ELEM_W-1:0]     req_element,
  input  logic [POS_W-1:0]      req_position,
  output bdq_rsp_t              rsp,
  output logic [ELEM_BITS-1:0]  rd_data
);

  logic [ELEM_BITS-1:0] mem [CAPACITY];

  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  bdq_rsp_t             rsp_r, rsp_nxt;
  logic [ELEM_BITS-1:0] rd_data_r;

  logic             full, empty, in_range;
  logic [PTR_W-1:0] offset, ring_addr, head_dec, addr;
  logic [PTR_W:0]   sum;
  logic             mem_we, mem_re;

  assign full     = (cnt_r == CNT_W'(CAPACITY));
  assign empty    = (cnt_r == '0);
  assign in_range = (32'(req_position) < 32'(cnt_r));
  assign head_dec = (head_r == '0) ? PTR_W'(CAPACITY - 1) : head_r - PTR_W'(1);

  // Logical offset from the head; only used by requests that are in range.
  always_comb begin
    case (bdq_func_t'(req_func))
      FN_INS_TAIL: offset = PTR_W'(cnt_r);
      FN_RD_TAIL:  offset = PTR_W'(cnt_r - CNT_W'(1));
      FN_RD_INDEX: offset = PTR_W'(req_position);
      default:     offset = '0;
    endcase
  end

  assign sum       = {1'b0, head_r} + {1'b0, offset};
  assign ring_addr = (sum >= (PTR_W+1)'(CAPACITY)) ? PTR_W'(sum - (PTR_W+1)'(CAPACITY))
                                                   : sum[PTR_W-1:0];

  always_comb begin
    head_nxt        = head_r;
    cnt_nxt         = cnt_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    addr            = ring_addr;
    rsp_nxt.hit     = 1'b0;
    rsp_nxt.status  = ST_OK;
    case (bdq_func_t'(req_func))
      FN_INS_HEAD: begin
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          addr     = head_dec;
          head_nxt = head_dec;
          cnt_nxt  = cnt_r + CNT_W'(1);
          mem_we   = req_valid;
        end
      end
      FN_INS_TAIL: begin
        if (full) begin
          rsp_nxt.status = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
          mem_we  = req_valid;
        end
      end
      FN_REM_HEAD: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          head_nxt = (head_r == PTR_W'(CAPACITY - 1)) ? '0 : head_r + PTR_W'(1);
          cnt_nxt  = cnt_r - CNT_W'(1);
        end
      end
      FN_REM_TAIL: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      FN_RD_HEAD, FN_RD_TAIL: begin
        if (empty) begin
          rsp_nxt.status = ST_EMPTY;
        end else begin
          rsp_nxt.hit = 1'b1;
          mem_re      = req_valid;
        end
      end
      FN_RD_INDEX: begin
        if (!in_range) begin
          rsp_nxt.status = ST_RANGE;
        end else begin
          rsp_nxt.hit = 1'b1;
          mem_re      = req_valid;
        end
      end
      default: begin
      end
    endcase
    rsp_nxt.count = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else if (req_valid) begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      rsp_r <= rsp_nxt;
    end
  end

  // Each request makes at most one access, so a write and a later read of the
  // same slot always belong to different requests and need no forwarding.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= ELEM_BITS'(req_element);
    end
    if (mem_re) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rsp     = rsp_r;
  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bounded_deque_with_index_read.sv =====
// Top level of the bounded deque: stream handshake, pipeline control, result register.
//
// A bounded double-ended list of element words kept in a ring memory with a head
// pointer and a fill count. Each request inserts or removes at either end, or reads
// the head, the tail or the element at a logical index, and returns exactly one
// result. One request is accepted per clock as long as the receiver keeps up. The
// element memory is read at the edge that accepts the request, and the output
// register loads from the ring's read register when the request stage advances,
// which a stalled receiver can hold back. A result held by the receiver blocks the
// next request once the request stage behind it is occupied. The memory needs no
// clearing after reset, so requests are taken as soon as reset is released.
module bounded_deque_with_index_read
  import bdq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // func[2:0], element[34:3], position[42:35], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // read_value[31:0], hit[32], count_now[41:33],
                                  // status[43:42], zero pad
);

  logic                 in_accept, adv;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 out_valid_r, out_valid_nxt;
  bdq_rsp_t             rsp;
  logic [ELEM_BITS-1:0] rd_data;

  logic [ELEM_W-1:0]    value_r;
  logic                 hit_r;
  logic [COUNT_W-1:0]   count_r;
  bdq_status_t          status_r;

  assign in_accept = in_tvalid && in_tready;
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = rst_n && (!s1_valid_r || adv);

  bdq_ring u_ring (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (in_accept),
    .req_func     (in_tdata[2:0]),
    .req_element  (in_tdata[34:3]),
    .req_position (in_tdata[42:35]),
    .rsp          (rsp),
    .rd_data      (rd_data)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      value_r  <= rsp.hit ? ELEM_W'(rd_data) : '0;
      hit_r    <= rsp.hit;
      count_r  <= COUNT_W'(rsp.count);
      status_r <= rsp.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, status_r, count_r, hit_r, value_r};

  a_hit_ok : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && hit_r |-> status_r == ST_OK)
    else $error("hit reported with a failing status");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !hit_r |-> value_r == '0)
    else $error("read value not zero without a hit");

  a_count_max : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(count_r) <= CAPACITY)
    else $error("count beyond capacity");

  a_full_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status_r == ST_FULL |-> 32'(count_r) == CAPACITY)
    else $error("full status with a count below capacity");

  a_empty_count : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status_r == ST_EMPTY |-> count_r == '0)
    else $error("empty status with stored elements");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the bounded deque with index read.
module tb_top
  import bdq_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Func code that the block must answer but otherwise ignore.
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  localparam int MIX_BROAD   = 0;
  localparam int MIX_FILL    = 1;
  localparam int MIX_DRAIN   = 2;
  localparam int HOLD_CYCLES = 200;
  localparam int PRINT_CAP   = 40;

  typedef struct packed {
    logic [ELEM_W-1:0]  value;
    logic               hit;
    logic [COUNT_W-1:0] count;
    bdq_status_t        status;
  } deque_reply_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ELEM_W-1:0] elem;
    logic [POS_W-1:0]  pos;
    logic              typed;
    deque_reply_t      want;
  } deque_row_t;

  localparam deque_reply_t NO_REPLY = '0;

  // Rows with typed answers follow from reset state and the extremes; the rest go
  // through the predictor.
  localparam int N_ROWS = 25;
  localparam deque_row_t DIRECTED [N_ROWS] = '{
    '{FN_RD_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 9'd0, ST_EMPTY}},
    '{FN_RD_TAIL,  32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0, 1'b0, 9'd0, ST_EMPTY}},
    '{FN_RD_INDEX, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 9'd0, ST_RANGE}},
    '{FN_RD_INDEX, 32'h0000_0000, 8'hFF, 1'b1, '{32'h0, 1'b0, 9'd0, ST_RANGE}},
    '{FN_REM_HEAD, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 9'd0, ST_EMPTY}},
    '{FN_REM_TAIL, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, 1'b0, 9'd0, ST_EMPTY}},
    '{FN_UNUSED,   32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0, 1'b0, 9'd0, ST_OK}},
    '{FN_INS_TAIL, 32'hFFFF_FFFF, 8'h00, 1'b1, '{32'h0, 1'b0, 9'd1, ST_OK}},
    '{FN_INS_HEAD, 32'h0000_0000, 8'hFF, 1'b1, '{32'h0, 1'b0, 9'd2, ST_OK}},
    '{FN_RD_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{32'h0000_0000, 1'b1, 9'd2, ST_OK}},
    '{FN_RD_TAIL,  32'h0000_0000, 8'h00, 1'b1, '{32'hFFFF_FFFF, 1'b1, 9'd2, ST_OK}},
    '{FN_RD_INDEX, 32'h0000_0000, 8'h01, 1'b1, '{32'hFFFF_FFFF, 1'b1, 9'd2, ST_OK}},
    '{FN_RD_INDEX, 32'h0000_0000, 8'h02, 1'b1, '{32'h0, 1'b0, 9'd2, ST_RANGE}},
    '{FN_INS_HEAD, 32'h8000_0001, 8'h00, 1'b0, NO_REPLY},
    '{FN_INS_TAIL, 32'h1234_5678, 8'h00, 1'b0, NO_REPLY},
    '{FN_RD_INDEX, 32'h0000_0000, 8'h00, 1'b0, NO_REPLY},
    '{FN_RD_INDEX, 32'h0000_0000, 8'h03, 1'b0, NO_REPLY},
    '{FN_REM_HEAD, 32'h0000_0000, 8'h00, 1'b0, NO_REPLY},
    '{FN_RD_HEAD,  32'h0000_0000, 8'h00, 1'b0, NO_REPLY},
    '{FN_REM_TAIL, 32'h0000_0000, 8'h00, 1'b0, NO_REPLY},
    '{FN_RD_TAIL,  32'h0000_0000, 8'h00, 1'b0, NO_REPLY},
    '{FN_UNUSED,   32'h5A5A_5A5A, 8'h80, 1'b0, NO_REPLY},
    '{FN_REM_TAIL, 32'h0000_0000, 8'h00, 1'b0, NO_REPLY},
    '{FN_REM_TAIL, 32'h0000_0000, 8'h00, 1'b0, NO_REPLY},
    '{FN_REM_HEAD, 32'h0000_0000, 8'h00, 1'b0, NO_REPLY}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;

  bounded_deque_with_index_read dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Shadow copy of the deque.
  logic [ELEM_W-1:0] ring_mem [CAPACITY];
  logic [PTR_W-1:0]  ring_head = '0;
  int unsigned       ring_fill = 0;

  deque_reply_t replies_due [$];
  int           fails     = 0;
  bit           src_idle  = 1'b1;
  bit           sink_idle = 1'b1;
  bit           hold_req  = 1'b0;

  function automatic deque_reply_t deque_apply(input logic [FUNC_W-1:0] f,
                                               input logic [ELEM_W-1:0] e,
                                               input logic [POS_W-1:0]  p);
    deque_reply_t r;
    r = '0;
    r.status = ST_OK;
    case (f)
      FN_INS_HEAD, FN_INS_TAIL: begin
        if (ring_fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (f == FN_INS_HEAD) begin
          ring_head = ring_head - 1'b1;
          ring_mem[ring_head] = e;
          ring_fill++;
        end else begin
          ring_mem[ring_head + PTR_W'(ring_fill)] = e;
          ring_fill++;
        end
      end
      FN_REM_HEAD, FN_REM_TAIL: begin
        if (ring_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (f == FN_REM_HEAD) ring_head = ring_head + 1'b1;
          ring_fill--;
        end
      end
      FN_RD_HEAD, FN_RD_TAIL: begin
        if (ring_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.hit   = 1'b1;
          r.value = (f == FN_RD_HEAD) ? ring_mem[ring_head]
                                      : ring_mem[ring_head + PTR_W'(ring_fill - 1)];
        end
      end
      FN_RD_INDEX: begin
        if (p >= ring_fill) begin
          r.status = ST_RANGE;
        end else begin
          r.hit   = 1'b1;
          r.value = ring_mem[ring_head + p];
        end
      end
      default: ;
    endcase
    r.count = COUNT_W'(ring_fill);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (fails < PRINT_CAP)
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fails++;
  endtask

  // Offers one item, waits for it to be taken and records what it must return.
  task automatic offer(input logic [FUNC_W-1:0] f, input logic [ELEM_W-1:0] e,
                       input logic [POS_W-1:0] p, input logic typed,
                       input deque_reply_t want);
    deque_reply_t predicted;
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, p, e, f};
    do @(posedge clk); while (!in_tready);
    predicted = deque_apply(f, e, p);
    replies_due.push_back(typed ? want : predicted);
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic offer_random(input int mix);
    int unsigned       r;
    logic [FUNC_W-1:0] f;
    logic [POS_W-1:0]  p;
    r = $urandom_range(0, 99);
    if (mix == MIX_FILL) begin
      if (r < 93)      f = $urandom_range(0, 1) ? FN_INS_HEAD : FN_INS_TAIL;
      else if (r < 98) f = FN_RD_INDEX;
      else             f = $urandom_range(0, 1) ? FN_RD_TAIL : FN_UNUSED;
    end else if (mix == MIX_DRAIN) begin
      if (r < 88)      f = $urandom_range(0, 1) ? FN_REM_HEAD : FN_REM_TAIL;
      else if (r < 96) f = FN_RD_INDEX;
      else             f = FN_RD_HEAD;
    end else begin
      if (r < 30)      f = $urandom_range(0, 1) ? FN_INS_HEAD : FN_INS_TAIL;
      else if (r < 48) f = $urandom_range(0, 1) ? FN_REM_HEAD : FN_REM_TAIL;
      else if (r < 62) f = $urandom_range(0, 1) ? FN_RD_HEAD : FN_RD_TAIL;
      else if (r < 95) f = FN_RD_INDEX;
      else             f = FN_UNUSED;
    end
    // Aim most indexed reads inside the list so they hit.
    if (ring_fill > 0 && $urandom_range(0, 3) != 0)
      p = POS_W'($urandom_range(0, ring_fill - 1));
    else
      p = POS_W'($urandom_range(0, 255));
    offer(f, $urandom, p, 1'b0, NO_REPLY);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    deque_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        flag_mismatch("unexpected item", out_tdata[31:0], 32'h0);
      end else begin
        want = replies_due.pop_front();
        if (out_tdata[31:0] !== want.value)
          flag_mismatch("read_value", out_tdata[31:0], want.value);
        if (out_tdata[32] !== want.hit)
          flag_mismatch("hit", 32'(out_tdata[32]), 32'(want.hit));
        if (out_tdata[41:33] !== want.count)
          flag_mismatch("count_now", 32'(out_tdata[41:33]), 32'(want.count));
        if (out_tdata[43:42] !== want.status)
          flag_mismatch("status", 32'(out_tdata[43:42]), 32'(want.status));
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      offer(DIRECTED[i].func, DIRECTED[i].elem, DIRECTED[i].pos, DIRECTED[i].typed,
            DIRECTED[i].want);

    repeat (25) offer_random(MIX_BROAD);

    // Stall the output while filling, so the block backs up and drops in_tready.
    hold_req = 1'b1;
    while (ring_fill < CAPACITY) offer_random(MIX_FILL);
    repeat (8) offer_random(MIX_FILL);

    while (ring_fill > 160) offer_random(MIX_DRAIN);
    repeat (6) offer_random(MIX_DRAIN);

    src_idle  = 1'b0;
    sink_idle = 1'b0;
    repeat (25) offer_random(MIX_BROAD);
    in_tvalid <= 1'b0;

    while (replies_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #500us;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/bdq_pkg.sv
rtl/core/bdq_ring.sv
rtl/core/bounded_deque_with_index_read.sv
test/tb_top.sv
